[design/ssi_pkg.sv]
package ssi_pkg;

   // Table size and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Word field widths
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;
   localparam int RSP_W    = 16;

   // Request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

[design/sorted_set_insert_unit.sv]
// Sorted set insert unit: keeps an ascending table of up to CAPACITY distinct
// signed 32-bit values. An insert word finds the first entry not smaller than
// its value with one shared 32-bit comparator, stepping through the table
// memory one entry at a time (read, then compare). A duplicate or a full
// table is rejected; otherwise the later entries move up one place, one at a
// time (read, then write) through the table memory's one read and one write
// port, and the value is written into the freed slot. One word is worked on
// at a time; the result sits in an output register, so the next request word
// is taken while it waits.
module sorted_set_insert_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ssi_pkg::VALUE_W-1:0] req_tdata, // [31:0] value
   input  logic                     req_tuser,  // [0] kind
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [ssi_pkg::RSP_W-1:0] rsp_tdata  // [3:0] position, [5:4] status,
                                                // [10:6] fill, [15:11] zero
);
   import ssi_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          ptr_ff, ptr_in;
   logic [VALUE_W-1:0]        value_ff, value_in;
   logic                      dup_ff, dup_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;

   // Table memory
   logic [VALUE_W-1:0]        entry_mem_ff [CAPACITY];
   logic [VALUE_W-1:0]        rd_data_ff;
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr;
   logic [IDX_W-1:0]          mem_raddr;
   logic [VALUE_W-1:0]        mem_wdata;

   // Shared comparator
   logic                      cmp_lt;
   logic                      cmp_eq;
   logic [CNT_W-1:0]          ptr_dec;
   logic                      accept;

   assign cmp_lt  = $signed(rd_data_ff) < $signed(value_ff);
   assign cmp_eq  = rd_data_ff == value_ff;
   assign ptr_dec = ptr_ff - 1'b1;
   assign accept  = req_tvalid && req_tready;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      value_in     = value_ff;
      dup_in       = dup_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[IDX_W-1:0];
      mem_wdata    = value_ff;
      mem_raddr    = idx_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in    = '0;
               status_in = STATUS_DONE;
               if (req_tuser == KIND_CLEAR) begin
                  count_in = '0;
                  state_in = ST_FINISH;
               end else begin
                  value_in = req_tdata;
                  idx_in   = '0;
                  dup_in   = 1'b0;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         // Fetch the next entry, or stop at the end of the held entries
         ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (cmp_lt) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end else begin
               dup_in   = cmp_eq;
               state_in = ST_DECIDE;
            end
         end
         // Duplicate check wins over full check
         ST_DECIDE: begin
            if (dup_ff) begin
               status_in = STATUS_DUP;
               state_in  = ST_FINISH;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               status_in = STATUS_FULL;
               state_in  = ST_FINISH;
            end else begin
               ptr_in = count_ff;
               if (count_ff == idx_ff) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_SHIFT_RD;
               end
            end
         end
         // Move entries up one place, top down
         ST_SHIFT_RD: begin
            mem_raddr = ptr_dec[IDX_W-1:0];
            state_in  = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[IDX_W-1:0];
            mem_wdata = rd_data_ff;
            ptr_in    = ptr_dec;
            if (ptr_dec == idx_ff) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_PLACE: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
            pos_in   = POS_W'(idx_ff);
            state_in = ST_FINISH;
         end
         // Load the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({FILL_W'(count_ff), status_ff, pos_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      value_ff    <= value_in;
      dup_ff      <= dup_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem_ff[mem_raddr];
   end

endmodule

[design/ssi_checker.sv]
module ssi_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [ssi_pkg::RSP_W-1:0] rsp_tdata
);
   import ssi_pkg::*;

   // Fill never exceeds the table size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:6] <= FILL_W'(CAPACITY))
      else $error("fill above capacity");

   // Status uses only defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:4] == STATUS_DONE || rsp_tdata[5:4] == STATUS_DUP
                      || rsp_tdata[5:4] == STATUS_FULL))
      else $error("undefined status code");

   // A rejected insert reports position zero
   a_reject_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[5:4] != STATUS_DONE) |-> rsp_tdata[3:0] == '0)
      else $error("rejected word with nonzero position");

   // The unit is busy right after taking a request word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready right after accept");

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response changed while stalled");

endmodule

bind sorted_set_insert_unit ssi_checker u_ssi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[test/sorted_set_insert_unit_tb.sv]
module sorted_set_insert_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssi_pkg::*;

   localparam int ITEM_TOTAL   = 600;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 100;

   // One expected response word, by field
   typedef struct {
      logic [POS_W-1:0]    position;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill;
   } outcome_type;

   // Scoreboard: keeps its own sorted table and the queue of expected outcomes
   class set_scoreboard;
      logic [VALUE_W-1:0] held [CAPACITY];
      int                 held_count;
      outcome_type        expected_outcomes [$];
      int                 errors;

      function new();
         held_count = 0;
         errors     = 0;
      endfunction

      task report(string what);
         if (errors < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
         end
         errors++;
      endtask

      // Apply one accepted request word to the table and queue its outcome
      function void note_request(logic kind, logic [VALUE_W-1:0] value);
         outcome_type outcome;
         int          slot;
         int          i;
         slot             = 0;
         outcome.position = '0;
         outcome.status   = STATUS_DONE;
         if (kind == KIND_CLEAR) begin
            held_count = 0;
         end else begin
            // first entry not smaller than the value, signed order
            while (slot < held_count && $signed(held[slot]) < $signed(value)) slot++;
            if (slot < held_count && held[slot] == value) begin
               outcome.status = STATUS_DUP;
            end else if (held_count >= CAPACITY) begin
               outcome.status = STATUS_FULL;
            end else begin
               for (i = held_count; i > slot; i--) held[i] = held[i-1];
               held[slot]       = value;
               held_count++;
               outcome.position = POS_W'(slot);
            end
         end
         outcome.fill = FILL_W'(held_count);
         expected_outcomes.push_back(outcome);
      endfunction

      // Compare one accepted response word with the oldest expectation
      task check_response(logic [RSP_W-1:0] word);
         outcome_type want;
         if (expected_outcomes.size() == 0) begin
            report($sformatf("unexpected response word %h", word));
            return;
         end
         want = expected_outcomes.pop_front();
         if (word[POS_W-1:0] !== want.position ||
             word[POS_W +: STATUS_W] !== want.status ||
             word[POS_W+STATUS_W +: FILL_W] !== want.fill ||
             word[RSP_W-1:POS_W+STATUS_W+FILL_W] !== '0) begin
            report($sformatf("word %h: want position %0d status %0d fill %0d",
                             word, want.position, want.status, want.fill));
         end
      endtask

      function int pending();
         return expected_outcomes.size();
      endfunction

      // A value already in the table, to provoke duplicates
      function logic [VALUE_W-1:0] some_held();
         if (held_count == 0) return $urandom;
         return held[$urandom_range(0, held_count - 1)];
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata  = '0;    // [31:0] value
   logic               req_tuser  = 1'b0;  // [0] kind
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;          // [3:0] position, [5:4] status,
                                           // [10:6] fill, [15:11] zero

   bit                 no_idle      = 1'b0;
   bit                 hold_pending = 1'b0;
   int                 cycle_count  = 0;
   set_scoreboard      sb = new();

   sorted_set_insert_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_set_insert_unit_tb NOT OK");
         $finish;
      end
   end

   // Offer one request word after a random gap; valid stays high when gap is zero
   task automatic send_word(logic kind, logic [VALUE_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, value);
   endtask

   // Random insert value: mostly small values and table hits so duplicates are common
   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return VALUE_W'(int'($urandom_range(0, 60)) - 30);
         4: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h8000_0001;
               default: return 32'h7fff_fffe;
            endcase
         end
         5, 6: return sb.some_held();
         7: return sb.some_held() + 1;
         default: return $urandom;
      endcase
   endfunction

   // Response side: random stalls, one long hold-off on request
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall        = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata);
      end
   end

   // Request side and end of run
   initial begin
      int   sent;
      int   i;
      logic kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicates, fill to capacity, full, clear
      send_word(KIND_INSERT, 32'h0000_0000);
      send_word(KIND_INSERT, 32'h8000_0000);
      send_word(KIND_INSERT, 32'h7fff_ffff);
      send_word(KIND_INSERT, 32'h0000_0000);
      send_word(KIND_INSERT, 32'hffff_ffff);
      send_word(KIND_INSERT, 32'h0000_0001);
      for (i = 0; i < 10; i++) send_word(KIND_INSERT, VALUE_W'(1000 * (i + 1)));
      send_word(KIND_INSERT, VALUE_W'(-1000));
      send_word(KIND_INSERT, 32'h0000_022b);   // new value, table full
      send_word(KIND_INSERT, 32'h7fff_ffff);   // duplicate in a full table
      send_word(KIND_INSERT, 32'h8000_0000);
      send_word(KIND_CLEAR,  32'hffff_ffff);
      send_word(KIND_INSERT, 32'h0000_1234);
      sent = 22;

      // random
      for (; sent < ITEM_TOTAL; sent++) begin
         if (sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (sent == 200) hold_pending = 1'b1;
         if (sent == 400) begin
            // sender pause until the block has drained
            req_tvalid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
            @(posedge clock);
         end
         kind = ($urandom_range(0, 29) == 0) ? KIND_CLEAR : KIND_INSERT;
         send_word(kind, (kind == KIND_CLEAR) ? VALUE_W'($urandom) : random_value());
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("sorted_set_insert_unit_tb OK");
      end else begin
         $display("sorted_set_insert_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

[filelist.f]
design/ssi_pkg.sv
design/sorted_set_insert_unit.sv
design/ssi_checker.sv
test/sorted_set_insert_unit_tb.sv
